// ===== rtl/core/lmdg_pkg.sv =====
// Shared types, widths and constants of the lattice mean-distance gradient block.
// No dependencies; used by lmdg_ctrl, lmdg_datapath and the top level.
package lmdg_pkg;

    localparam int MAX_POINTS_DEF = 1024;

    localparam int IDX_W   = 8;
    localparam int PEAK_W  = 16;
    localparam int COEF_W  = 16;
    localparam int ROW_W   = 3 * COEF_W;
    localparam int IN_W    = 3 * IDX_W + 3 * PEAK_W;
    localparam int D_W     = 26;
    localparam int S_W     = 50;
    localparam int X_W     = 64;
    localparam int ROOT_W  = 32;
    localparam int SQREM_W = 35;
    localparam int NUM_W   = 48;
    localparam int DEN_W   = 34;
    localparam int REM_W   = 35;
    localparam int U_W     = 17;
    localparam int SUM_W   = 34;
    localparam int GRAD_W  = 24;
    localparam int CNT_W   = 11;
    localparam int STEP_W  = 6;
    localparam int SEL_W   = 4;

    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(NUM_W - 1);
    localparam logic [SEL_W-1:0]  LAST_ROW  = SEL_W'(2);
    localparam logic [SEL_W-1:0]  LAST_ENT  = SEL_W'(8);

    // Configuration register indexes.
    localparam logic [1:0] REG_BASIS_X = 2'd0;
    localparam logic [1:0] REG_BASIS_Y = 2'd1;
    localparam logic [1:0] REG_BASIS_Z = 2'd2;

    typedef logic [2:0][ROW_W-1:0] basis_t;
    typedef logic [8:0][GRAD_W-1:0] grad_arr_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DROW,
        OP_SQ,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_UDIV_INIT,
        OP_DIV_STEP,
        OP_USTORE,
        OP_ACC,
        OP_MDIV_INIT,
        OP_MSTORE,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [SEL_W-1:0] sel;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic zero_res;
        logic last;
        logic out_busy;
    } status_t;

    // Row and column of a gradient entry in row-major order.
    function automatic logic [1:0] row_of(input logic [SEL_W-1:0] e);
        logic [1:0] r;
        case (e)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] col_of(input logic [SEL_W-1:0] e);
        logic [1:0] c;
        case (e)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/lmdg_ctrl.sv =====
// Sequencer of the gradient block: steps the datapath through one point.
// Depends on lmdg_pkg for the command and status types.
module lmdg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lmdg_pkg::status_t status,
    output lmdg_pkg::cmd_t    cmd
);
    import lmdg_pkg::*;

    typedef enum logic [14:0] {
        ST_IDLE   = 15'b000000000000001,
        ST_DROW   = 15'b000000000000010,
        ST_SQ     = 15'b000000000000100,
        ST_ZCHK   = 15'b000000000001000,
        ST_SQRT   = 15'b000000000010000,
        ST_UINIT  = 15'b000000000100000,
        ST_UDIV   = 15'b000000001000000,
        ST_USTORE = 15'b000000010000000,
        ST_ACC    = 15'b000000100000000,
        ST_FIN    = 15'b000001000000000,
        ST_MWAIT  = 15'b000010000000000,
        ST_MINIT  = 15'b000100000000000,
        ST_MDIV   = 15'b001000000000000,
        ST_MSTORE = 15'b010000000000000,
        ST_EMIT   = 15'b100000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SEL_W-1:0]  sel_reg, sel_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        sel_next   = sel_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    sel_next   = '0;
                    state_next = status.full ? ST_FIN : ST_DROW;
                end
            end
            ST_DROW:
            begin
                cmd.op = OP_DROW;
                if (sel_reg == LAST_ROW)
                begin
                    sel_next   = '0;
                    state_next = ST_SQ;
                end
                else
                begin
                    sel_next = sel_reg + 1'b1;
                end
            end
            ST_SQ:
            begin
                cmd.op = OP_SQ;
                if (sel_reg == LAST_ROW)
                begin
                    state_next = ST_ZCHK;
                end
                else
                begin
                    sel_next = sel_reg + 1'b1;
                end
            end
            ST_ZCHK:
            begin
                if (status.zero_res)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.op     = OP_SQRT_INIT;
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.op = OP_SQRT_STEP;
                if (step_reg == SQRT_LAST)
                begin
                    sel_next   = '0;
                    state_next = ST_UINIT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_UINIT:
            begin
                cmd.op     = OP_UDIV_INIT;
                step_next  = '0;
                state_next = ST_UDIV;
            end
            ST_UDIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (step_reg == DIV_LAST)
                begin
                    state_next = ST_USTORE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_USTORE:
            begin
                cmd.op = OP_USTORE;
                if (sel_reg == LAST_ROW)
                begin
                    sel_next   = '0;
                    state_next = ST_ACC;
                end
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = ST_UINIT;
                end
            end
            ST_ACC:
            begin
                cmd.op = OP_ACC;
                if (sel_reg == LAST_ENT)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    sel_next = sel_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                state_next = status.last ? ST_MWAIT : ST_IDLE;
            end
            ST_MWAIT:
            begin
                if (!status.out_busy)
                begin
                    sel_next   = '0;
                    state_next = ST_MINIT;
                end
            end
            ST_MINIT:
            begin
                cmd.op     = OP_MDIV_INIT;
                step_next  = '0;
                state_next = ST_MDIV;
            end
            ST_MDIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (step_reg == DIV_LAST)
                begin
                    state_next = ST_MSTORE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_MSTORE:
            begin
                cmd.op = OP_MSTORE;
                if (sel_reg == LAST_ENT)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = ST_MINIT;
                end
            end
            ST_EMIT:
            begin
                cmd.op     = OP_EMIT;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

// ===== rtl/core/lmdg_datapath.sv =====
// Datapath of the gradient block: residual, square root, shared divider, sums, means.
// Depends on lmdg_pkg; driven by commands from lmdg_ctrl.
module lmdg_datapath #(
    parameter int MAX_POINTS = lmdg_pkg::MAX_POINTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lmdg_pkg::basis_t                     basis,
    input  logic [lmdg_pkg::IN_W-1:0]            in_data,
    input  logic                                 in_last,
    input  lmdg_pkg::cmd_t                       cmd,
    output lmdg_pkg::status_t                    status,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output lmdg_pkg::grad_arr_t                  grads,
    output logic [lmdg_pkg::CNT_W-1:0]           point_count,
    output logic                                 count_overflow
);
    import lmdg_pkg::*;

    localparam int PC_W = $clog2(MAX_POINTS + 1);
    localparam int EX_W = (PC_W > CNT_W) ? PC_W : CNT_W;
    localparam logic [PC_W-1:0] MAX_CNT = PC_W'(MAX_POINTS);

    localparam logic [NUM_W-1:0] U_LIMIT   = NUM_W'(32768);
    localparam logic [NUM_W-1:0] POS_LIMIT = NUM_W'(8388607);
    localparam logic [NUM_W-1:0] NEG_LIMIT = NUM_W'(8388608);

    // Point registers.
    logic signed [IDX_W-1:0]  m_reg [3];
    logic signed [PEAK_W-1:0] n_reg [3];
    logic                     last_reg;

    // Residual, squared length and square root.
    logic signed [D_W-1:0]    d_reg [3];
    logic [S_W-1:0]           s_reg;
    logic [X_W-1:0]           x_reg;
    logic [SQREM_W-1:0]       sq_rem_reg;
    logic [ROOT_W-1:0]        root_reg;

    // Shared restoring divider.
    logic [NUM_W-1:0]         num_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [NUM_W-1:0]         q_reg;
    logic                     neg_reg;

    logic signed [U_W-1:0]    u_reg [3];
    logic signed [SUM_W-1:0]  sum_reg [9];
    logic [PC_W-1:0]          cnt_reg;
    logic                     ovf_reg;

    logic                     out_valid_reg;
    grad_arr_t                grad_reg;
    logic [CNT_W-1:0]         out_cnt_reg;
    logic                     out_ovf_reg;

    // Combinational terms.
    logic [1:0]               row_sel, ent_row, ent_col;
    logic [ROW_W-1:0]         brow;
    logic signed [D_W-1:0]    prod0, prod1, prod2, d_new;
    logic signed [D_W-1:0]    d_cur;
    logic signed [2*D_W-1:0]  d_sq;
    logic [S_W-1:0]           s_base;
    logic [SQREM_W-1:0]       sq_shift, sq_trial;
    logic [D_W-1:0]           d_abs;
    logic [REM_W-1:0]         div_shift, den_ext;
    logic [NUM_W-1:0]         q_lim, q_sat;
    logic [U_W-1:0]           u_mag;
    logic signed [D_W-1:0]    acc_prod;
    logic signed [SUM_W:0]    acc_wide;
    logic signed [SUM_W-1:0]  acc_sat;
    logic signed [SUM_W-1:0]  sum_cur;
    logic [SUM_W-1:0]         sum_abs;
    logic [GRAD_W-1:0]        g_mag;
    logic [EX_W-1:0]          cnt_ext;

    assign row_sel = cmd.sel[1:0];
    assign ent_row = row_of(cmd.sel);
    assign ent_col = col_of(cmd.sel);
    assign brow    = basis[row_sel];

    assign prod0 = D_W'($signed(brow[COEF_W-1:0])) * D_W'(m_reg[0]);
    assign prod1 = D_W'($signed(brow[2*COEF_W-1:COEF_W])) * D_W'(m_reg[1]);
    assign prod2 = D_W'($signed(brow[3*COEF_W-1:2*COEF_W])) * D_W'(m_reg[2]);
    assign d_new = prod0 + prod1 + prod2 - D_W'(n_reg[row_sel]);

    assign d_cur  = d_reg[row_sel];
    assign d_sq   = (2*D_W)'(d_cur) * (2*D_W)'(d_cur);
    assign s_base = (row_sel == 2'd0) ? '0 : s_reg;
    assign d_abs  = d_cur[D_W-1] ? D_W'(-d_cur) : D_W'(d_cur);

    // One result bit of the integer square root per step.
    assign sq_shift = {sq_rem_reg[SQREM_W-3:0], x_reg[X_W-1:X_W-2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};

    // One quotient bit per step.
    assign div_shift = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
    assign den_ext   = REM_W'(den_reg);

    assign q_lim = (cmd.op == OP_USTORE) ? U_LIMIT : (neg_reg ? NEG_LIMIT : POS_LIMIT);
    assign q_sat = (q_reg > q_lim) ? q_lim : q_reg;
    assign u_mag = q_sat[U_W-1:0];
    assign g_mag = q_sat[GRAD_W-1:0];

    assign acc_prod = D_W'(u_reg[ent_row]) * D_W'(m_reg[ent_col]);
    assign sum_cur  = sum_reg[cmd.sel];
    assign acc_wide = (SUM_W+1)'(sum_cur) + (SUM_W+1)'(acc_prod);
    always_comb
    begin
        if (acc_wide[SUM_W] != acc_wide[SUM_W-1])
        begin
            acc_sat = acc_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_wide[SUM_W-1:0];
        end
    end
    assign sum_abs = sum_cur[SUM_W-1] ? SUM_W'(-sum_cur) : SUM_W'(sum_cur);

    assign status.full     = (cnt_reg >= MAX_CNT);
    assign status.zero_res = (s_reg == '0);
    assign status.last     = last_reg;
    assign status.out_busy = out_valid_reg;

    assign cnt_ext = EX_W'(cnt_reg);

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                m_reg[0] <= in_data[7:0];
                m_reg[1] <= in_data[15:8];
                m_reg[2] <= in_data[23:16];
                n_reg[0] <= in_data[39:24];
                n_reg[1] <= in_data[55:40];
                n_reg[2] <= in_data[71:56];
            end
            OP_DROW:
            begin
                d_reg[row_sel] <= d_new;
            end
            OP_SQ:
            begin
                s_reg <= s_base + S_W'(d_sq);
            end
            OP_SQRT_INIT:
            begin
                x_reg      <= {s_reg, 14'b0};
                sq_rem_reg <= '0;
                root_reg   <= '0;
            end
            OP_SQRT_STEP:
            begin
                x_reg <= {x_reg[X_W-3:0], 2'b00};
                if (sq_shift >= sq_trial)
                begin
                    sq_rem_reg <= sq_shift - sq_trial;
                    root_reg   <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg <= sq_shift;
                    root_reg   <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            OP_UDIV_INIT:
            begin
                // round(|d| * 2^22 / len) as floor((2|d| * 2^22 + len) / (2 len))
                num_reg <= (NUM_W'(d_abs) << 23) + NUM_W'(root_reg);
                den_reg <= DEN_W'(root_reg) << 1;
                neg_reg <= d_cur[D_W-1];
                rem_reg <= '0;
                q_reg   <= '0;
            end
            OP_MDIV_INIT:
            begin
                num_reg <= (NUM_W'(sum_abs) << 1) + NUM_W'(cnt_reg);
                den_reg <= DEN_W'(cnt_reg) << 1;
                neg_reg <= sum_cur[SUM_W-1];
                rem_reg <= '0;
                q_reg   <= '0;
            end
            OP_DIV_STEP:
            begin
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                if (div_shift >= den_ext)
                begin
                    rem_reg <= div_shift - den_ext;
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_shift;
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
                end
            end
            OP_USTORE:
            begin
                u_reg[row_sel] <= neg_reg ? U_W'(-u_mag) : U_W'(u_mag);
            end
            OP_MSTORE:
            begin
                if (cnt_reg == '0)
                begin
                    grad_reg[cmd.sel] <= '0;
                end
                else
                begin
                    grad_reg[cmd.sel] <= neg_reg ? GRAD_W'(-g_mag) : g_mag;
                end
            end
            OP_EMIT:
            begin
                out_cnt_reg <= cnt_ext[CNT_W-1:0];
                out_ovf_reg <= ovf_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Control and accumulator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    last_reg <= in_last;
                    if (status.full)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                OP_ACC:
                begin
                    sum_reg[cmd.sel] <= acc_sat;
                end
                OP_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    cnt_reg       <= '0;
                    ovf_reg       <= 1'b0;
                    for (int i = 0; i < 9; i++)
                    begin
                        sum_reg[i] <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign grads          = grad_reg;
    assign point_count    = out_cnt_reg;
    assign count_overflow = out_ovf_reg;

endmodule

// ===== rtl/core/lattice_mean_distance_gradient_top.sv =====
// Top level of the lattice mean-distance gradient block: ports, basis registers, checks.
// Depends on lmdg_pkg, lmdg_ctrl and lmdg_datapath.
//
// Usage: write the three basis rows (signed Q4.12 triples) on the cfg channel while the
// block is idle, then stream points on the s_axis channel. Each point carries a Miller
// index triple and a measured peak; tlast marks the final point of a set. For every point
// the block forms the residual to the predicted peak, normalizes it and adds the unit
// residual times the index into nine saturating sums.
// A point's work is set by the 32-step square root and three 48-step quotients on the
// shared divider; a point with zero residual skips both, and a point beyond the maximum
// count only sets the overflow flag. The last point of a set adds nine 48-step mean
// divisions before the result appears on m_axis. No new point is taken until then.
// The result register holds one finished set; the block keeps accepting points of the next
// set while it waits, and only stalls at the next set's end until the receiver takes it.
// Reset clears the basis, the sums, the point count and the overflow flag, and drops any
// pending result. A cfg transaction is always accepted; an index of 3 is ignored.
module lattice_mean_distance_gradient_top #(
    parameter int MAX_POINTS = lmdg_pkg::MAX_POINTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // Configuration writes.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_data,
    // Point stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,  // index_h, index_k, index_l, peak_x, peak_y, peak_z
    input  logic         s_axis_tlast,  // last_point
    // Result stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [231:0] m_axis_tdata,  // grad_xh .. grad_zl, point_count, zero fill
    output logic         m_axis_tuser   // count_overflow
);
    import lmdg_pkg::*;

    basis_t           basis_reg;
    cmd_t             cmd;
    status_t          status;
    grad_arr_t        grads;
    logic [CNT_W-1:0] point_count;
    logic             count_overflow;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            basis_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BASIS_X: basis_reg[0] <= cfg_data;
                REG_BASIS_Y: basis_reg[1] <= cfg_data;
                REG_BASIS_Z: basis_reg[2] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    lmdg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lmdg_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .basis          (basis_reg),
        .in_data        (s_axis_tdata),
        .in_last        (s_axis_tlast),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .grads          (grads),
        .point_count    (point_count),
        .count_overflow (count_overflow)
    );

    assign m_axis_tdata = {5'b0, point_count, grads};
    assign m_axis_tuser = count_overflow;

    // The sequencer takes one point at a time: after a transaction it is busy.
    a_one_point_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("point accepted while the previous one is still in work");

    // A set that overflowed must report the saturated count.
    a_overflow_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (point_count == CNT_W'(MAX_POINTS)))
        else $error("overflow flagged without a saturated point count");

    // A new result is only raised when the previous one has been taken.
    a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("pending result dropped or overwritten");

endmodule

// ===== tb/sv/lmdg_checker.sv =====
// Checker for the lattice mean-distance gradient block: watches the basis writes,
// the point stream and the result stream, predicts each set's gradient and compares.
// Depends on lmdg_pkg for the register indexes and widths.
module lmdg_checker #(
    parameter int MAX_POINTS = lmdg_pkg::MAX_POINTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [231:0] m_axis_tdata,
    input  logic         m_axis_tuser,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lmdg_pkg::*;

    localparam longint SUM_HI  = 64'sd8589934591;
    localparam longint SUM_LO  = -64'sd8589934592;
    localparam longint GRAD_HI = 64'sd8388607;
    localparam longint GRAD_LO = -64'sd8388608;
    localparam longint UNIT    = 64'sd32768;

    typedef struct {
        logic [GRAD_W-1:0] grad [9];
        logic [CNT_W-1:0]  count;
        logic              overflow;
    } gradient_result_t;

    logic [ROW_W-1:0]  basis_rows [3];
    longint            grad_sums [9];
    int                set_points;
    bit                set_overflow;
    gradient_result_t  expected_gradients [$];

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // Quotient rounded to nearest, ties away from zero; den is positive.
    function automatic longint round_div(input longint num, input longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = (mag * 2 + den) / (den * 2);
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic accumulate_point(input logic [71:0] data, input logic last);
        longint            idx [3];
        longint            peak [3];
        longint            resid [3];
        longint unsigned   sq;
        longint unsigned   len;
        longint            unit_c;
        gradient_result_t  res;
        for (int c = 0; c < 3; c++)
        begin
            idx[c]  = longint'($signed(data[8*c +: 8]));
            peak[c] = longint'($signed(data[24 + 16*c +: 16]));
        end
        if (set_points >= MAX_POINTS)
            set_overflow = 1'b1;
        else
        begin
            set_points++;
            sq = 0;
            for (int r = 0; r < 3; r++)
            begin
                resid[r] = -peak[r];
                for (int c = 0; c < 3; c++)
                    resid[r] += longint'($signed(basis_rows[r][16*c +: 16])) * idx[c];
                sq += longint'(resid[r] * resid[r]);
            end
            // A zero residual counts the point but leaves the sums alone.
            if (sq != 0)
            begin
                len = int_sqrt(sq * 64'd16384);
                for (int r = 0; r < 3; r++)
                begin
                    unit_c = clip(round_div(resid[r] * 64'sd4194304, len), -UNIT, UNIT);
                    for (int c = 0; c < 3; c++)
                        grad_sums[3*r+c] = clip(grad_sums[3*r+c] + unit_c * idx[c],
                                                SUM_LO, SUM_HI);
                end
            end
        end
        if (last)
        begin
            for (int e = 0; e < 9; e++)
                res.grad[e] = (set_points == 0) ? '0 :
                    GRAD_W'(clip(round_div(grad_sums[e], set_points), GRAD_LO, GRAD_HI));
            res.count    = CNT_W'(set_points);
            res.overflow = set_overflow;
            expected_gradients.push_back(res);
            for (int e = 0; e < 9; e++)
                grad_sums[e] = 0;
            set_points   = 0;
            set_overflow = 1'b0;
        end
    endtask

    task automatic check_result();
        gradient_result_t want;
        if (expected_gradients.size() == 0)
        begin
            $display("[%0t] result transaction with no set pending", $realtime);
            fail_count++;
            return;
        end
        want = expected_gradients.pop_front();
        for (int e = 0; e < 9; e++)
            if (m_axis_tdata[GRAD_W*e +: GRAD_W] !== want.grad[e])
                report_mismatch($sformatf("gradient entry %0d", e),
                                longint'($signed(m_axis_tdata[GRAD_W*e +: GRAD_W])),
                                longint'($signed(want.grad[e])));
        if (m_axis_tdata[216 +: CNT_W] !== want.count)
            report_mismatch("point count", m_axis_tdata[216 +: CNT_W], want.count);
        if (m_axis_tdata[231:227] !== '0)
            report_mismatch("zero fill", m_axis_tdata[231:227], 0);
        if (m_axis_tuser !== want.overflow)
            report_mismatch("count overflow", m_axis_tuser, want.overflow);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
                basis_rows[r] = '0;
            for (int e = 0; e < 9; e++)
                grad_sums[e] = 0;
            set_points   = 0;
            set_overflow = 1'b0;
            fail_count   = 0;
            expected_gradients.delete();
            pending      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_BASIS_X: basis_rows[0] = cfg_data;
                    REG_BASIS_Y: basis_rows[1] = cfg_data;
                    REG_BASIS_Z: basis_rows[2] = cfg_data;
                    default:     ;
                endcase
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                accumulate_point(s_axis_tdata, s_axis_tlast);
            pending = expected_gradients.size();
        end
    end

endmodule

// ===== tb/sv/tb_lattice_mean_distance_gradient_top.sv =====
// Testbench top for the lattice mean-distance gradient block: clock, reset, basis
// writes, point stimulus and the verdict. Depends on lmdg_pkg, the block and lmdg_checker.
module tb_lattice_mean_distance_gradient_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lmdg_pkg::*;

    // Index beyond the three basis rows; the block must ignore it.
    localparam logic [1:0] REG_UNUSED = 2'd3;
    // Cycles to let a point still in flight finish before touching the basis.
    localparam int SETTLE_CYCLES = 800;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int HOLD_CYCLES   = 6000;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [47:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [231:0] m_axis_tdata;
    logic         m_axis_tuser;
    int           fail_count;
    int           pending;

    // Our own copy of the basis, used only to aim peaks near the predicted position.
    logic signed [15:0] basis_coef [3][3];
    int   burst_left;
    int   cycle_count;
    bit   hold_request;
    bit   hold_started;
    int   hold_left;
    int   stall_timer;
    bit   stall_mode;

    lattice_mean_distance_gradient_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lmdg_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("lattice_mean_distance_gradient_top regression: fail");
            $finish;
        end
    end

    // Result receiver. It alternates between always-ready stretches and random
    // stalling, and once, on request, refuses every result for a long stretch so
    // the finished set blocks the next set's end and the point input backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_started  <= 1'b0;
            hold_left     <= 0;
            stall_timer   <= 0;
            stall_mode    <= 1'b0;
        end
        else if (hold_request && !hold_started)
        begin
            hold_started  <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (stall_timer == 0)
            begin
                stall_timer <= $urandom_range(16, 200);
                stall_mode  <= 1'($urandom_range(0, 1));
            end
            else
                stall_timer <= stall_timer - 1;
            m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    // One configuration transaction; cfg_valid stays high for back-to-back writes.
    task automatic write_reg(input logic [1:0] index, input logic [47:0] value);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic load_basis(input logic signed [15:0] coef [3][3]);
        for (int r = 0; r < 3; r++)
        begin
            basis_coef[r] = coef[r];
            write_reg(r == 0 ? REG_BASIS_X : (r == 1 ? REG_BASIS_Y : REG_BASIS_Z),
                      {coef[r][2], coef[r][1], coef[r][0]});
        end
        cfg_valid <= 1'b0;
    endtask

    // Sends one point; the sender works in bursts with random gaps between them.
    task automatic send_point(input logic signed [7:0] idx [3],
                              input logic signed [15:0] peak [3], input bit last);
        int  gap;
        bit  taken;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {peak[2], peak[1], peak[0], idx[2], idx[1], idx[0]};
        s_axis_tlast  <= last;
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        while (!taken);
        burst_left--;
    endtask

    // Picks a random index and a peak near, at, or far from the predicted spot.
    task automatic random_point(input bit last);
        logic signed [7:0]  idx [3];
        logic signed [15:0] peak [3];
        longint             aim;
        int                 style;
        style = $urandom_range(0, 7);
        for (int c = 0; c < 3; c++)
            idx[c] = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                 : 8'($signed($urandom_range(0, 8)) - 4);
        for (int r = 0; r < 3; r++)
        begin
            aim = 0;
            for (int c = 0; c < 3; c++)
                aim += longint'(basis_coef[r][c]) * longint'(idx[c]);
            if (style == 0)
                aim += 0;
            else if (style < 6)
                aim += longint'($urandom_range(0, 512)) - 256;
            else
                aim = longint'($signed(16'($urandom)));
            peak[r] = (aim > 32767 || aim < -32768) ? 16'($urandom) : 16'(aim);
        end
        send_point(idx, peak, last);
    endtask

    // Lets every expected result arrive and any point still in flight settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_basis(input int span);
        logic signed [15:0] coef [3][3];
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                coef[r][c] = (span >= 32768) ? 16'($urandom) :
                             16'($signed($urandom_range(0, 2*span)) - span);
        load_basis(coef);
    endtask

    task automatic fixed_basis(input logic [15:0] value);
        logic signed [15:0] coef [3][3];
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                coef[r][c] = value;
        load_basis(coef);
    endtask

    initial
    begin
        logic signed [7:0]  idx [3];
        logic signed [15:0] peak [3];
        logic signed [15:0] coef [3][3];
        int                 set_left;

        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_BASIS_X;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        hold_request  = 1'b0;
        burst_left    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part. With the reset basis and a zero peak the residual is zero;
        // a set of only such points must report zero gradients with its count.
        idx = '{8'sd0, 8'sd0, 8'sd0};
        peak = '{16'sd0, 16'sd0, 16'sd0};
        send_point(idx, peak, 1'b0);
        idx = '{8'sd127, -8'sd128, 8'sd1};
        send_point(idx, peak, 1'b1);
        drain();

        // The unused index must not disturb the basis.
        write_reg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
        coef = '{'{16'sh7FFF, -16'sh8000, 16'sd4096},
                 '{-16'sh8000, 16'sh7FFF, -16'sd4096},
                 '{16'sd1, -16'sd1, 16'sh7FFF}};
        load_basis(coef);
        idx = '{8'sd127, 8'sd127, 8'sd127};
        peak = '{-16'sh8000, -16'sh8000, -16'sh8000};
        send_point(idx, peak, 1'b0);
        idx = '{-8'sd128, -8'sd128, -8'sd128};
        peak = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        send_point(idx, peak, 1'b0);
        idx = '{8'sd127, -8'sd128, 8'sd127};
        peak = '{16'sh7FFF, -16'sh8000, 16'sd0};
        send_point(idx, peak, 1'b0);
        // Peak exactly on the predicted spot: zero residual inside a busy set.
        idx = '{8'sd1, 8'sd0, 8'sd0};
        peak = '{16'sh7FFF, -16'sh8000, 16'sd1};
        send_point(idx, peak, 1'b0);
        // One unit away from the prediction along a single axis.
        idx = '{8'sd0, 8'sd0, 8'sd0};
        peak = '{16'sd0, 16'sd0, 16'sd1};
        send_point(idx, peak, 1'b1);
        // A single-point set.
        idx = '{-8'sd1, 8'sd2, -8'sd3};
        peak = '{16'sd100, -16'sd200, 16'sd300};
        send_point(idx, peak, 1'b1);
        for (int i = 0; i < 10; i++)
            random_point(i == 9);
        drain();

        // Random part across several basis settings, the extremes among them.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: random_basis(4096);
                1: fixed_basis(16'h7FFF);
                2: fixed_basis(16'h8000);
                3: random_basis(32768);
                4: random_basis(512);
                default: random_basis(16384);
            endcase
            set_left = $urandom_range(1, 10);
            for (int i = 0; i < 130; i++)
            begin
                // Long result hold-off while points keep coming.
                if (phase == 3 && i == 20)
                    hold_request <= 1'b1;
                set_left--;
                random_point(set_left == 0 || i == 129);
                if (set_left == 0)
                    set_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                           : $urandom_range(1, 8);
            end
            drain();
        end

        if (fail_count == 0)
            $display("lattice_mean_distance_gradient_top regression: pass");
        else
            $display("lattice_mean_distance_gradient_top regression: fail");
        $finish;
    end

endmodule
